// ===== design/c3bc_pkg.sv =====
// ----------------------------------------------------------------------------
// c3bc_pkg: shared types and constants for the 3x3 convolution core
// Coefficient and accumulator widths, default parameter values, register
// indexes, request commands and the control struct for the shared MAC unit.
// ----------------------------------------------------------------------------
package c3bc_pkg;

    // Default sizes of the frame store and the coefficient format
    localparam int DEF_MAX_WIDTH      = 256;
    localparam int DEF_MAX_HEIGHT     = 256;
    localparam int DEF_COEF_FRAC_BITS = 10;

    // Register port widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int DIM_CFG_W  = 9;

    // Pixel and coefficient arithmetic
    localparam int PIX_W   = 8;
    localparam int COEF_W  = 16;
    localparam int PROD_W  = COEF_W + PIX_W + 1;   // signed coef x unsigned pixel
    localparam int ACC_W   = PROD_W + 4;           // nine products, no overflow
    localparam int PIX_MAX = 255;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_MODE   = 3'd2,
        CFG_KROW0  = 3'd3,
        CFG_KROW1  = 3'd4,
        CFG_KROW2  = 3'd5,
        CFG_SPARE0 = 3'd6,
        CFG_SPARE1 = 3'd7
    } cfg_idx_t;

    // Request commands
    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_FETCH = 1'b1
    } cmd_t;

    // Control for the shared MAC unit
    typedef struct packed {
        logic clear;    // start of a new output pixel
        logic step;     // pixel and coefficient are valid this cycle
    } mac_ctl_t;

endpackage

// ===== design/c3bc_frame_store.sv =====
// ----------------------------------------------------------------------------
// c3bc_frame_store: single-port-write, single-port-read frame memory
// Holds one grey frame in raster order. Read data is registered.
// ----------------------------------------------------------------------------
module c3bc_frame_store
    import c3bc_pkg::*;
#(
    parameter int DEPTH  = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
    parameter int ADDR_W = 16
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [PIX_W-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [PIX_W-1:0]  rd_data
);

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/c3bc_divider.sv =====
// ----------------------------------------------------------------------------
// c3bc_divider: restoring divider, one quotient bit per cycle
// Splits the raster position into row (quotient) and column (remainder).
// ----------------------------------------------------------------------------
module c3bc_divider
    import c3bc_pkg::*;
#(
    parameter int DVD_W = 17,
    parameter int DVS_W = 9
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic [DVD_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] quot_reg, quot_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   trial;
    logic             fits;

    // One shift-and-subtract step
    always_comb
    begin
        trial     = {rem_reg, quot_reg[DVD_W-1]};
        fits      = (trial >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : DVS_W'(trial);
            quot_next = DVD_W'({quot_reg, fits});
            cnt_next  = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath, no reset
    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

// ===== design/c3bc_mac.sv =====
// ----------------------------------------------------------------------------
// c3bc_mac: shared multiply-accumulate unit with output clamp
// One coefficient x pixel product a cycle, registered, then summed exactly.
// ----------------------------------------------------------------------------
module c3bc_mac
    import c3bc_pkg::*;
#(
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mac_ctl_t                 ctl,
    input  logic signed [COEF_W-1:0] coef,
    input  logic [PIX_W-1:0]         pix,
    output logic                     busy,
    output logic [PIX_W-1:0]         result
);

    logic                     prod_v_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  shifted;
    logic signed [PIX_W:0]    pix_s;

    // Product and running sum
    always_comb
    begin
        pix_s     = signed'({1'b0, pix});
        prod_next = PROD_W'(coef) * PROD_W'(pix_s);
        acc_next  = acc_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_v_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
        end
        else
        begin
            prod_v_reg <= ctl.step;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    // Drop the fraction, clamp to 0..255
    always_comb
    begin
        shifted = acc_reg >>> COEF_FRAC_BITS;
        if (acc_reg < 0)
        begin
            result = '0;
        end
        else if (shifted > ACC_W'(PIX_MAX))
        begin
            result = PIX_W'(PIX_MAX);
        end
        else
        begin
            result = shifted[PIX_W-1:0];
        end
    end

    assign busy = prod_v_reg;

endmodule

// ===== design/conv3x3_border_clamp_core.sv =====
// ----------------------------------------------------------------------------
// conv3x3_border_clamp_core: 3x3 convolution over a stored grey frame
// Load a frame pixel by pixel, then fetch filtered pixels in raster order.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid/in_stall, cmd, pixel_in): cmd 0 loads the next
//  pixel of the frame in raster order, cmd 1 requests the next filtered
//  pixel. Loads beyond a full frame and fetches before it is full are
//  dropped. A load leaves the block idle, ready for the next request.
//  A fetch runs a row/column split (one quotient bit per cycle in the
//  divider), nine frame-store reads through the single shared MAC, and a
//  pipeline drain; in_stall is high meanwhile, so the divider and the one
//  MAC hold off the next request.
//  Output channel (out_valid/out_stall, pixel_out, frame_done): one result
//  per fetch; frame_done marks the last pixel, which re-arms the block for
//  a new frame. The result sits in an output register, so the next request
//  is taken while it waits; a finished fetch holds in drain while the
//  receiver stalls the previous result.
//  Registers are written through cfg_we/cfg_index/cfg_data; write them only
//  while idle, as the block does not enforce it. Reset clears the counters,
//  sets width/height to 256, wrap, zero kernel; the frame store is not cleared.
// ----------------------------------------------------------------------------
module conv3x3_border_clamp_core
    import c3bc_pkg::*;
#(
    parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT     = DEF_MAX_HEIGHT,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // register port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // request channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  cmd,
    input  logic [PIX_W-1:0]      pixel_in,
    // result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [PIX_W-1:0]      pixel_out,
    output logic                  frame_done
);

    localparam int X_W    = $clog2(MAX_WIDTH + 1);
    localparam int Y_W    = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIV   = 4'b0010,
        S_MAC   = 4'b0100,
        S_DRAIN = 4'b1000
    } state_t;

    // Registers
    state_t                state_reg, state_next;
    logic [DIM_CFG_W-1:0]  width_reg, height_reg;
    logic                  mode_reg;
    logic [CFG_DATA_W-1:0] krow_reg [3];
    logic [CNT_W-1:0]      loaded_reg, loaded_next;
    logic [CNT_W-1:0]      emitted_reg, emitted_next;
    logic                  last_reg, last_next;
    logic [1:0]            j_reg, j_next;
    logic [1:0]            k_reg, k_next;
    logic                  tap_v_reg, tap_v_next;
    logic signed [COEF_W-1:0] coef_reg, coef_next;
    logic                  out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]      pix_out_reg, pix_out_next;
    logic                  done_reg, done_next;

    // Combinational
    logic [X_W-1:0]    w_eff;
    logic [Y_W-1:0]    h_eff;
    logic [CNT_W-1:0]  size;
    logic              frame_full;
    logic [CNT_W-1:0]  pos;
    logic              accept;
    logic              wr_en;
    logic              div_start;
    logic              div_busy;
    logic [CNT_W-1:0]  div_quot;
    logic [X_W-1:0]    div_rem;
    logic [X_W-1:0]    x_cur;
    logic [Y_W-1:0]    y_cur;
    logic [X_W-1:0]    xs;
    logic [Y_W-1:0]    ys;
    logic [ADDR_W-1:0] rd_addr;
    logic [PIX_W-1:0]  rd_data;
    mac_ctl_t          mac_ctl;
    logic              mac_busy;
    logic [PIX_W-1:0]  mac_result;

    // Effective frame size, dimensions saturated to 1..MAX
    always_comb
    begin
        if (width_reg == '0)
            w_eff = X_W'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = X_W'(MAX_WIDTH);
        else
            w_eff = X_W'(width_reg);

        if (height_reg == '0)
            h_eff = Y_W'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = Y_W'(MAX_HEIGHT);
        else
            h_eff = Y_W'(height_reg);

        size       = CNT_W'(w_eff) * CNT_W'(h_eff);
        frame_full = (loaded_reg >= size);
        pos        = (emitted_reg >= size) ? size - CNT_W'(1) : emitted_reg;
    end

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign wr_en     = accept && (cmd == CMD_LOAD) && !frame_full;
    assign div_start = accept && (cmd == CMD_FETCH) && frame_full;

    // Register port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= DIM_CFG_W'(256);
            height_reg  <= DIM_CFG_W'(256);
            mode_reg    <= 1'b1;
            krow_reg[0] <= '0;
            krow_reg[1] <= '0;
            krow_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_WIDTH:  width_reg   <= cfg_data[DIM_CFG_W-1:0];
                CFG_HEIGHT: height_reg  <= cfg_data[DIM_CFG_W-1:0];
                CFG_MODE:   mode_reg    <= cfg_data[0];
                CFG_KROW0:  krow_reg[0] <= cfg_data;
                CFG_KROW1:  krow_reg[1] <= cfg_data;
                CFG_KROW2:  krow_reg[2] <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Row and column of the output pixel
    c3bc_divider #(
        .DVD_W (CNT_W),
        .DVS_W (X_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (pos),
        .divisor   (w_eff),
        .busy      (div_busy),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign x_cur = div_rem;
    assign y_cur = Y_W'(div_quot);

    // Tap coordinates with mirror or wrap at the borders
    always_comb
    begin
        if (x_cur == '0 && j_reg == 2'd2)
            xs = mode_reg ? w_eff - X_W'(1) : '0;
        else if (j_reg == 2'd0 && x_cur == w_eff - X_W'(1))
            xs = mode_reg ? '0 : w_eff - X_W'(1);
        else
            xs = X_W'({1'b0, x_cur} + (X_W+1)'(1) - (X_W+1)'(j_reg));

        if (y_cur == '0 && k_reg == 2'd2)
            ys = mode_reg ? h_eff - Y_W'(1) : '0;
        else if (k_reg == 2'd0 && y_cur == h_eff - Y_W'(1))
            ys = mode_reg ? '0 : h_eff - Y_W'(1);
        else
            ys = Y_W'({1'b0, y_cur} + (Y_W+1)'(1) - (Y_W+1)'(k_reg));

        rd_addr = ADDR_W'(ys) * ADDR_W'(w_eff) + ADDR_W'(xs);
    end

    c3bc_frame_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (loaded_reg[ADDR_W-1:0]),
        .wr_data (pixel_in),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign mac_ctl.clear = div_start;
    assign mac_ctl.step  = tap_v_reg;

    c3bc_mac #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .coef   (coef_reg),
        .pix    (rd_data),
        .busy   (mac_busy),
        .result (mac_result)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        loaded_next    = loaded_reg;
        emitted_next   = emitted_reg;
        last_next      = last_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        tap_v_next     = 1'b0;
        coef_next      = signed'(krow_reg[j_reg][{k_reg, 4'b0000} +: COEF_W]);
        out_valid_next = out_valid_reg && out_stall;
        pix_out_next   = pix_out_reg;
        done_next      = done_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (wr_en)
                begin
                    loaded_next = loaded_reg + CNT_W'(1);
                end
                if (div_start)
                begin
                    last_next  = (pos == size - CNT_W'(1));
                    state_next = S_DIV;
                    if (pos == size - CNT_W'(1))
                    begin
                        loaded_next  = '0;
                        emitted_next = '0;
                    end
                    else
                    begin
                        emitted_next = pos + CNT_W'(1);
                    end
                end
            end
            S_DIV:
            begin
                j_next = 2'd0;
                k_next = 2'd0;
                if (!div_busy)
                begin
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                // issue one tap a cycle
                tap_v_next = 1'b1;
                if (j_reg == 2'd2)
                begin
                    j_next = 2'd0;
                    k_next = k_reg + 2'd1;
                    if (k_reg == 2'd2)
                    begin
                        state_next = S_DRAIN;
                    end
                end
                else
                begin
                    j_next = j_reg + 2'd1;
                end
            end
            S_DRAIN:
            begin
                if (!tap_v_reg && !mac_busy && !(out_valid_reg && out_stall))
                begin
                    out_valid_next = 1'b1;
                    pix_out_next   = mac_result;
                    done_next      = last_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            loaded_reg    <= '0;
            emitted_reg   <= '0;
            last_reg      <= 1'b0;
            j_reg         <= '0;
            k_reg         <= '0;
            tap_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            emitted_reg   <= emitted_next;
            last_reg      <= last_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            tap_v_reg     <= tap_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        coef_reg    <= coef_next;
        pix_out_reg <= pix_out_next;
        done_reg    <= done_next;
    end

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pix_out_reg;
    assign frame_done = done_reg;

    // Checks
    a_fetch_starts_split: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (state_reg == S_DIV) && div_busy)
        else $error("fetch on a full frame did not start the divider");

    a_div_idle_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC || state_reg == S_DRAIN) |-> !div_busy)
        else $error("divider still running during the MAC sequence");

    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(loaded_reg) <= DEPTH)
        else $error("load count beyond frame store depth");

    a_result_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg ##1 out_valid_reg) |-> $past(state_reg) == S_DRAIN)
        else $error("result raised outside the drain state");

endmodule

// ===== sim/tb_conv3x3_border_clamp_core.sv =====
// ----------------------------------------------------------------------------
// tb_conv3x3_border_clamp_core: self-checking bench for the 3x3 convolution
// Loads grey frames, fetches the filtered pixels and compares every result
// with a local predictor of the frame store, the border folding and the
// clamped fixed-point sum. Both channels idle at random outside steady phases.
// ----------------------------------------------------------------------------
module tb_conv3x3_border_clamp_core
    import c3bc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET  = 1750;
    localparam int DRAIN_CYCLES = 64;
    localparam int STORE_DEPTH  = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

    typedef enum logic {
        BORDER_MIRROR = 1'b0,
        BORDER_WRAP   = 1'b1
    } border_t;

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic             last;
    } conv_result_t;

    // ------------------------------------------------------------------------
    // Predictor of the core and store of awaited results
    // ------------------------------------------------------------------------
    class conv_scoreboard_t;
        logic [PIX_W-1:0] frame_px [0:STORE_DEPTH-1];
        int unsigned      loaded_px;
        int unsigned      emitted_px;
        logic [8:0]       width_reg;
        logic [8:0]       height_reg;
        border_t          border;
        logic [47:0]      kern_row [3];
        bit               frame_rearmed;
        conv_result_t     awaited_pixels [$];
        int unsigned      error_count;

        function new();
            loaded_px   = 0;
            emitted_px  = 0;
            width_reg   = 9'd256;
            height_reg  = 9'd256;
            border      = BORDER_WRAP;
            kern_row[0] = '0;
            kern_row[1] = '0;
            kern_row[2] = '0;
            error_count = 0;
        endfunction

        function void write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_WIDTH:  width_reg   = data[8:0];
                CFG_HEIGHT: height_reg  = data[8:0];
                CFG_MODE:   border      = border_t'(data[0]);
                CFG_KROW0:  kern_row[0] = data[47:0];
                CFG_KROW1:  kern_row[1] = data[47:0];
                CFG_KROW2:  kern_row[2] = data[47:0];
                default:    ;   // unmapped index, dropped
            endcase
        endfunction

        // sizes saturate to 1..max when used
        function int unsigned frame_w();
            if (width_reg == 0) return 1;
            if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
            return 32'(width_reg);
        endfunction

        function int unsigned frame_h();
            if (height_reg == 0) return 1;
            if (height_reg > DEF_MAX_HEIGHT) return DEF_MAX_HEIGHT;
            return 32'(height_reg);
        endfunction

        // bring a coordinate in -1..m back into the frame
        function int fold(int c, int m);
            if (c < 0)
                return (border == BORDER_WRAP) ? c + m : -c - 1;
            if (c >= m)
                return (border == BORDER_WRAP) ? c - m : 2 * m - c - 1;
            return c;
        endfunction

        function logic [PIX_W-1:0] filtered_pixel(int unsigned pos, int w, int h);
            int                 y;
            int                 x;
            int                 addr;
            int                 pv;
            logic signed [15:0] coef;
            longint             acc;
            y   = pos / w;
            x   = pos % w;
            acc = 0;
            // j steps columns, k steps rows; K[j][k] lies at bits 16k of row j
            for (int k = -1; k <= 1; k++)
            begin
                for (int j = -1; j <= 1; j++)
                begin
                    addr = fold(y - k, h) * w + fold(x - j, w);
                    pv   = int'(frame_px[addr]);
                    coef = kern_row[j + 1][16 * (k + 1) +: 16];
                    acc  = acc + longint'(coef) * longint'(pv);
                end
            end
            if (acc < 0) return '0;
            acc = acc >>> DEF_COEF_FRAC_BITS;
            if (acc > PIX_MAX) return PIX_W'(PIX_MAX);
            return acc[PIX_W-1:0];
        endfunction

        // returns 1 when the request changes state
        function bit note_request(cmd_t c, logic [PIX_W-1:0] px);
            int unsigned  w;
            int unsigned  h;
            int unsigned  size;
            int unsigned  pos;
            conv_result_t res;
            w    = frame_w();
            h    = frame_h();
            size = w * h;
            if (c == CMD_LOAD)
            begin
                if (loaded_px >= size) return 0;
                frame_px[loaded_px] = px;
                loaded_px++;
                return 1;
            end
            if (loaded_px < size) return 0;
            // shrunk frame: an overrun count draws the new last pixel
            pos      = (emitted_px >= size) ? size - 1 : emitted_px;
            res.pix  = filtered_pixel(pos, w, h);
            res.last = (pos == size - 1);
            awaited_pixels.push_back(res);
            if (res.last)
            begin
                loaded_px     = 0;
                emitted_px    = 0;
                frame_rearmed = 1;
            end
            else
            begin
                emitted_px = pos + 1;
            end
            return 1;
        endfunction

        function void check_result(logic [PIX_W-1:0] pix, logic last);
            conv_result_t res;
            if (awaited_pixels.size() == 0)
            begin
                $display("%0t: unexpected result pixel_out=%0d frame_done=%b",
                         $time, pix, last);
                error_count++;
                return;
            end
            res = awaited_pixels.pop_front();
            if (pix !== res.pix)
            begin
                $display("%0t: pixel_out mismatch, expected %0d, actual %0d",
                         $time, res.pix, pix);
                error_count++;
            end
            if (last !== res.last)
            begin
                $display("%0t: frame_done mismatch, expected %b, actual %b",
                         $time, res.last, last);
                error_count++;
            end
        endfunction

        function int pending();
            return awaited_pixels.size();
        endfunction

        function void report_leftover();
            if (awaited_pixels.size() != 0)
            begin
                $display("%0t: %0d results never arrived, first expected %0d/%b",
                         $time, awaited_pixels.size(), awaited_pixels[0].pix,
                         awaited_pixels[0].last);
                error_count++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  cmd;
    logic [PIX_W-1:0]      pixel_in;
    logic                  out_valid;
    logic                  out_stall;
    logic [PIX_W-1:0]      pixel_out;
    logic                  frame_done;

    conv_scoreboard_t sb = new();
    bit               steady;         // no idling on either side
    int unsigned      n_effective;    // requests that changed state

    conv3x3_border_clamp_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .pixel_in   (pixel_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_out  (pixel_out),
        .frame_done (frame_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Overall limit
    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    task automatic send_request(cmd_t c, logic [PIX_W-1:0] px);
        while (!steady && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        pixel_in <= px;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        if (sb.note_request(c, px)) n_effective++;
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_register(idx, data);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // hold the sender until every awaited result is in
    task automatic hold_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // idle enough for a load-only tail to finish as well
    task automatic quiesce();
        hold_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_coef();
        int sel;
        int v;
        sel = $urandom_range(99);
        if (sel < 55)
        begin
            v = int'($urandom_range(640)) - 200;
            return v[15:0];
        end
        if (sel < 75) return 16'($urandom);
        case ($urandom_range(4))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'h0400;
            default: return 16'hFFFF;
        endcase
    endfunction

    task automatic configure_phase(int phase_no);
        logic [CFG_DATA_W-1:0] wd;
        logic [CFG_DATA_W-1:0] hd;
        logic [CFG_DATA_W-1:0] junk;
        int                    sel;
        junk = 48'({$urandom, $urandom});
        sel  = $urandom_range(99);
        // one widest and one tallest frame, otherwise small ones
        if (phase_no == 2)
        begin
            wd = (sel < 50) ? 48'd256 : 48'($urandom_range(257, 511));
            hd = 48'd1;
        end
        else if (phase_no == 4)
        begin
            wd = 48'd1;
            hd = (sel < 50) ? 48'd256 : 48'($urandom_range(257, 511));
        end
        else if (sel < 8)
        begin
            wd = 48'd0;
            hd = 48'($urandom_range(4));
        end
        else if (sel < 16)
        begin
            wd = 48'($urandom_range(1, 4));
            hd = 48'd0;
        end
        else
        begin
            wd = 48'($urandom_range(1, 10));
            hd = 48'($urandom_range(1, 10));
        end
        if ($urandom_range(99) < 30) wd = wd | (junk & ~48'h1FF);
        if ($urandom_range(99) < 30) hd = hd | ({junk[23:0], junk[47:24]} & ~48'h1FF);
        write_reg(CFG_WIDTH, wd);
        write_reg(CFG_HEIGHT, hd);
        write_reg(CFG_MODE, 48'({$urandom, $urandom}));
        for (int r = 0; r < 3; r++)
        begin
            write_reg(cfg_idx_t'(int'(CFG_KROW0) + r),
                      {pick_coef(), pick_coef(), pick_coef()});
        end
        if ($urandom_range(99) < 20)
            write_reg($urandom_range(1) ? CFG_SPARE1 : CFG_SPARE0, junk);
    endtask

    // load and drain one frame; a cut run stops part way through
    task automatic run_frame(bit cut);
        int unsigned      size;
        int unsigned      stop_after;
        int unsigned      steps;
        bit               full;
        int               sel;
        cmd_t             c;
        logic [PIX_W-1:0] px;
        size       = sb.frame_w() * sb.frame_h();
        stop_after = cut ? $urandom_range(1, 2 * size) : 32'hFFFF_FFFF;
        steps      = 0;
        sb.frame_rearmed = 0;
        while (!sb.frame_rearmed && steps < stop_after)
        begin
            full = (sb.loaded_px >= size);
            sel  = $urandom_range(99);
            px   = 8'($urandom);
            if (sel < 8)
                px = 8'h00;
            else if (sel < 16)
                px = 8'hFF;
            // now and then the command the block must drop
            if ($urandom_range(99) < 6)
                c = full ? CMD_LOAD : CMD_FETCH;
            else
                c = full ? CMD_FETCH : CMD_LOAD;
            send_request(c, px);
            if ($urandom_range(199) == 0) hold_for_results();
            steps++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall, check each accepted result
    // ------------------------------------------------------------------------
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
                sb.check_result(pixel_out, frame_done);
            out_stall <= !steady && ($urandom_range(99) < 31);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int phase_no;
        int guard;
        steady      = 1'b0;
        n_effective = 0;
        rst_n       = 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= CFG_WIDTH;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        cmd        <= CMD_LOAD;
        pixel_in   <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // 3x2 mirrored frame, kernel with both saturating extremes
        write_reg(CFG_WIDTH, 48'hFFFF_FFFF_FE03);
        write_reg(CFG_HEIGHT, 48'd2);
        write_reg(CFG_MODE, 48'(BORDER_MIRROR));
        write_reg(CFG_KROW0, {16'hFF00, 16'h0100, 16'h7FFF});
        write_reg(CFG_KROW1, {16'h0000, 16'h0400, 16'hFE00});
        write_reg(CFG_KROW2, {16'h8000, 16'h0080, 16'h0200});
        send_request(CMD_FETCH, 8'h5A);         // frame not yet full
        send_request(CMD_LOAD, 8'h00);
        send_request(CMD_LOAD, 8'hFF);
        send_request(CMD_LOAD, 8'hFF);
        send_request(CMD_LOAD, 8'h00);
        send_request(CMD_LOAD, 8'h11);
        send_request(CMD_LOAD, 8'hC8);
        send_request(CMD_LOAD, 8'h63);          // beyond a full frame
        repeat (6) send_request(CMD_FETCH, 8'h00);
        quiesce();

        // zero sizes act as a single pixel, wrapped
        write_reg(CFG_WIDTH, 48'd0);
        write_reg(CFG_HEIGHT, 48'h800);
        write_reg(CFG_MODE, 48'(BORDER_WRAP));
        send_request(CMD_LOAD, 8'hFF);
        send_request(CMD_FETCH, 8'hA5);
        quiesce();

        // shrink the frame under a count already past the new size
        write_reg(CFG_WIDTH, 48'd2);
        write_reg(CFG_HEIGHT, 48'd2);
        repeat (4) send_request(CMD_LOAD, 8'($urandom));
        repeat (3) send_request(CMD_FETCH, 8'h00);
        quiesce();
        write_reg(CFG_WIDTH, 48'd1);
        send_request(CMD_FETCH, 8'h00);

        // random frames
        phase_no = 0;
        while (n_effective < ITEM_TARGET)
        begin
            steady = (phase_no >= 6 && phase_no < 11);
            quiesce();
            configure_phase(phase_no);
            run_frame(phase_no != 2 && phase_no != 4 && $urandom_range(99) < 15);
            phase_no++;
        end

        // drain and finish
        in_valid <= 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.report_leftover();
        if (sb.error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
